@@ src/gtg_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_pkg: shared constants for go-to-goal steering
// Register indexes, CORDIC angle table, fixed-point helpers.
// ----------------------------------------------------------------------------
package gtg_pkg;

  localparam int FRACTION_BITS_DEF = 12;
  localparam int CORDIC_STAGES_DEF = 14;
  localparam int ATAN_ENTRIES = 20;

  // CORDIC datapath width: |dx|,|dy| < 2^16, growth < 1.65 plus shift floor slack
  localparam int XW = 19;
  localparam int ZW = 33;

  localparam logic [2:0] REG_TARGET_X  = 3'd0;
  localparam logic [2:0] REG_TARGET_Y  = 3'd1;
  localparam logic [2:0] REG_GAIN      = 3'd2;
  localparam logic [2:0] REG_MAX_LIN   = 3'd3;
  localparam logic [2:0] REG_MAX_ANG   = 3'd4;

  localparam logic signed [ZW-1:0] HALF_PI_Q30 = 33'sd1686629713;
  localparam logic signed [ZW-1:0] PI_Q30      = 33'sd3373259426;
  localparam logic [29:0] CORDIC_GAIN_Q30      = 30'd652032874;

  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0: r = 33'sd843314856;
      1: r = 33'sd497837829;
      2: r = 33'sd263043836;
      3: r = 33'sd133525158;
      4: r = 33'sd67021686;
      5: r = 33'sd33543515;
      6: r = 33'sd16775850;
      7: r = 33'sd8388437;
      8: r = 33'sd4194282;
      9: r = 33'sd2097149;
      10: r = 33'sd1048575;
      11: r = 33'sd524287;
      12: r = 33'sd262143;
      13: r = 33'sd131071;
      14: r = 33'sd65535;
      15: r = 33'sd32767;
      16: r = 33'sd16383;
      17: r = 33'sd8191;
      18: r = 33'sd4095;
      19: r = 33'sd2047;
      default: r = '0;
    endcase
    return r;
  endfunction

  typedef struct packed {
    logic [15:0] goal_x;
    logic [15:0] goal_y;
    logic [14:0] linear_gain;
    logic [14:0] max_linear_speed;
    logic [14:0] max_angular_speed;
  } cfg_t;

endpackage
`default_nettype wire

@@ src/gtg_cordic.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_cordic: pipelined CORDIC vectoring unit
// Quadrant pre-rotation stage followed by one register stage per iteration.
// ----------------------------------------------------------------------------
module gtg_cordic #(
  parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF,
  parameter int HW = 15
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          en,
  input  wire  logic                          in_valid,
  input  wire  logic signed [16:0]            in_dx,
  input  wire  logic signed [16:0]            in_dy,
  input  wire  logic signed [HW-1:0]          in_head,
  output logic                                out_valid,
  output logic signed [gtg_pkg::XW-1:0]       out_x,
  output logic signed [gtg_pkg::ZW-1:0]       out_z,
  output logic signed [HW-1:0]                out_head
);

  localparam int N = (CORDIC_STAGES < gtg_pkg::ATAN_ENTRIES) ? CORDIC_STAGES
                     : gtg_pkg::ATAN_ENTRIES;

  logic                              v  [N+1];
  logic signed [gtg_pkg::XW-1:0]     xs [N+1];
  logic signed [gtg_pkg::XW-1:0]     ys [N+1];
  logic signed [gtg_pkg::ZW-1:0]     zs [N+1];
  logic signed [HW-1:0]              hs [N+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
    if (en) begin
      hs[0] <= in_head;
      if (in_dx < 0) begin
        if (in_dy >= 0) begin
          xs[0] <= gtg_pkg::XW'(in_dy);
          ys[0] <= -gtg_pkg::XW'(in_dx);
          zs[0] <= gtg_pkg::HALF_PI_Q30;
        end else begin
          xs[0] <= -gtg_pkg::XW'(in_dy);
          ys[0] <= gtg_pkg::XW'(in_dx);
          zs[0] <= -gtg_pkg::HALF_PI_Q30;
        end
      end else begin
        xs[0] <= gtg_pkg::XW'(in_dx);
        ys[0] <= gtg_pkg::XW'(in_dy);
        zs[0] <= '0;
      end
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
      if (en) begin
        hs[i+1] <= hs[i];
        if (ys[i] >= 0) begin
          xs[i+1] <= xs[i] + (ys[i] >>> i);
          ys[i+1] <= ys[i] - (xs[i] >>> i);
          zs[i+1] <= zs[i] + gtg_pkg::atan_q30(i);
        end else begin
          xs[i+1] <= xs[i] - (ys[i] >>> i);
          ys[i+1] <= ys[i] + (xs[i] >>> i);
          zs[i+1] <= zs[i] - gtg_pkg::atan_q30(i);
        end
      end
    end
  end

  assign out_valid = v[N];
  assign out_x     = xs[N];
  assign out_z     = zs[N];
  assign out_head  = hs[N];

endmodule
`default_nettype wire

@@ src/gtg_steer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_steer: post-CORDIC pipeline
// Distance scaling, heading error wrap, decision, gain and saturation.
// ----------------------------------------------------------------------------
module gtg_steer #(
  parameter int FRACTION_BITS = gtg_pkg::FRACTION_BITS_DEF,
  parameter int HW = 15
) (
  input  wire  logic                          clk,
  input  wire  logic                          rst,
  input  wire  logic                          en,
  input  wire  gtg_pkg::cfg_t                 cfg,
  input  wire  logic                          in_valid,
  input  wire  logic signed [gtg_pkg::XW-1:0] in_x,
  input  wire  logic signed [gtg_pkg::ZW-1:0] in_z,
  input  wire  logic signed [HW-1:0]          in_head,
  output logic                                out_valid,
  output logic [14:0]                         out_fwd,
  output logic signed [15:0]                  out_turn
);

  localparam int S = 30 - FRACTION_BITS;
  localparam int EW = 24;
  localparam logic signed [gtg_pkg::ZW-1:0] PI_QF =
    gtg_pkg::ZW'((gtg_pkg::PI_Q30 + (64'sd1 <<< (S - 1))) >>> S);
  localparam logic signed [EW-1:0] PI_E  = EW'(PI_QF);
  localparam logic signed [EW-1:0] PI2_E = EW'(2 * PI_QF);
  localparam logic [EW-1:0] DIST_TH = EW'(((1 << FRACTION_BITS) + 5) / 10);
  localparam logic [EW-1:0] ANG_TH  = EW'((2 * (1 << FRACTION_BITS) + 5) / 10);

  // stage A: distance product, bearing rounding
  logic                      va;
  logic [49:0]               prod;
  logic signed [EW-1:0]      err_a;

  logic signed [gtg_pkg::ZW-1:0] bear;
  assign bear = (in_z + gtg_pkg::ZW'(64'sd1 <<< (S - 1))) >>> S;

  always_ff @(posedge clk) begin
    if (rst) va <= 1'b0;
    else if (en) va <= in_valid;
    if (en) begin
      prod  <= 50'(in_x[gtg_pkg::XW-2:0]) * 50'(gtg_pkg::CORDIC_GAIN_Q30);
      err_a <= EW'(bear) - EW'(in_head);
    end
  end

  // stage B: distance, wrap (error spans at most one extra turn)
  logic                 vb;
  logic [EW-1:0]        dist_b;
  logic signed [EW-1:0] err_b;
  logic [49:0]          prod_r;
  assign prod_r = prod + (50'd1 << 29);

  always_ff @(posedge clk) begin
    if (rst) vb <= 1'b0;
    else if (en) vb <= va;
    if (en) begin
      dist_b <= EW'(prod_r >> 30);
      if (err_a > PI_E) err_b <= err_a - PI2_E;
      else if (err_a < -PI_E) err_b <= err_a + PI2_E;
      else err_b <= err_a;
    end
  end

  // stage C: decision, gain product
  logic                 vc;
  logic                 drive_c, turn_c;
  logic [39:0]          gprod;
  logic signed [EW-1:0] err_c;
  logic [EW-1:0]        mag;
  assign mag = err_b[EW-1] ? EW'(-err_b) : EW'(err_b);

  always_ff @(posedge clk) begin
    if (rst) vc <= 1'b0;
    else if (en) vc <= vb;
    if (en) begin
      err_c   <= err_b;
      turn_c  <= (dist_b > DIST_TH) && (mag > ANG_TH);
      drive_c <= (dist_b > DIST_TH) && !(mag > ANG_TH);
      gprod   <= 40'(cfg.linear_gain) * 40'(dist_b) + 40'(64'd1 << (FRACTION_BITS - 1));
    end
  end

  // stage D: saturate and register result
  logic [39:0]          fwd_full;
  logic signed [EW:0]   turn_full;
  logic signed [EW:0]   amax;
  assign fwd_full  = gprod >> FRACTION_BITS;
  assign turn_full = (EW+1)'(err_c) <<< 1;
  assign amax      = (EW+1)'(cfg.max_angular_speed);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= vc;
    if (en) begin
      if (drive_c && fwd_full > 40'(cfg.max_linear_speed)) out_fwd <= cfg.max_linear_speed;
      else if (drive_c) out_fwd <= fwd_full[14:0];
      else out_fwd <= '0;
      if (!turn_c) out_turn <= '0;
      else if (turn_full > amax) out_turn <= 16'(amax);
      else if (turn_full < -amax) out_turn <= 16'(-amax);
      else out_turn <= 16'(turn_full);
    end
  end

endmodule
`default_nettype wire

@@ src/go_to_goal_steering.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_to_goal_steering: pose to velocity command toward a target point
// CORDIC vectoring pipeline plus steering stages.
// ----------------------------------------------------------------------------
// channel | direction | handshake
// pose    | in        | valid / stall
// command | out       | valid / stall
// One transaction per cycle while the output is not stalled; register stages:
// pre-rotation, one per CORDIC iteration (capped at ATAN_ENTRIES), four steering stages.
// The whole pipeline advances together; an output stall freezes every stage.
// Input stall follows output stall only when the output register is full.
// Reset clears valid bits and reloads the register defaults.
module go_to_goal_steering #(
  parameter int FRACTION_BITS = gtg_pkg::FRACTION_BITS_DEF,
  parameter int CORDIC_STAGES = gtg_pkg::CORDIC_STAGES_DEF
) (
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  logic               cfg_write,
  input  wire  logic [2:0]         cfg_index,
  input  wire  logic [15:0]        cfg_data,
  input  wire  logic               in_valid,
  output logic                     in_stall,
  input  wire  logic [15:0]        current_x,
  input  wire  logic [15:0]        current_y,
  input  wire  logic signed [14:0] current_heading,
  output logic                     out_valid,
  input  wire  logic               out_stall,
  output logic [14:0]              forward_speed,
  output logic signed [15:0]       turn_rate
);

  gtg_pkg::cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.goal_x            <= 16'd12288;
      cfg.goal_y            <= 16'd16384;
      cfg.linear_gain       <= 15'd4096;
      cfg.max_linear_speed  <= 15'd12288;
      cfg.max_angular_speed <= 15'd12288;
    end else if (cfg_write) begin
      unique case (cfg_index)
        gtg_pkg::REG_TARGET_X: cfg.goal_x            <= cfg_data;
        gtg_pkg::REG_TARGET_Y: cfg.goal_y            <= cfg_data;
        gtg_pkg::REG_GAIN:     cfg.linear_gain       <= cfg_data[14:0];
        gtg_pkg::REG_MAX_LIN:  cfg.max_linear_speed  <= cfg_data[14:0];
        gtg_pkg::REG_MAX_ANG:  cfg.max_angular_speed <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic signed [16:0] dx, dy;
  assign dx = $signed({1'b0, cfg.goal_x}) - $signed({1'b0, current_x});
  assign dy = $signed({1'b0, cfg.goal_y}) - $signed({1'b0, current_y});

  logic                              cv;
  logic signed [gtg_pkg::XW-1:0]     cx;
  logic signed [gtg_pkg::ZW-1:0]     cz;
  logic signed [14:0]                ch;

  gtg_cordic #(.CORDIC_STAGES(CORDIC_STAGES), .HW(15)) u_cordic (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .in_dx(dx), .in_dy(dy), .in_head(current_heading),
    .out_valid(cv), .out_x(cx), .out_z(cz), .out_head(ch)
  );

  gtg_steer #(.FRACTION_BITS(FRACTION_BITS), .HW(15)) u_steer (
    .clk(clk), .rst(rst), .en(en), .cfg(cfg),
    .in_valid(cv), .in_x(cx), .in_z(cz), .in_head(ch),
    .out_valid(out_valid), .out_fwd(forward_speed), .out_turn(turn_rate)
  );

endmodule
`default_nettype wire

@@ src/gtg_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gtg_checker: port-level checks for go_to_goal_steering
// Output handshake and command consistency.
// ----------------------------------------------------------------------------
module gtg_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire logic [14:0]        forward_speed,
  input wire logic signed [15:0] turn_rate
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(forward_speed) && $stable(turn_rate))
    else $error("stalled command changed");

  a_excl: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> forward_speed == 15'd0 || turn_rate == 16'sd0)
    else $error("drive and turn together");

  a_back: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

endmodule

bind go_to_goal_steering gtg_checker u_gtg_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .forward_speed(forward_speed), .turn_rate(turn_rate)
);
`default_nettype wire
